/* hdl/hsv_pkg.sv */
// Shared types and constants for the RGB to HSV converter.
package hsv_pkg;

  localparam int PIX_W = 8;            // width of every color component
  localparam int NUM_W = 16;           // width of a dividend before division
  localparam int QUO_W = 8;            // quotient bits produced by the divider
  localparam int QUEUE_DEPTH_DEF = 4;  // default depth of the front-to-back queue

  localparam int SAT_SCALE = 255;
  localparam int HUE_SCALE = 43;
  localparam logic [PIX_W-1:0] HUE_BASE_RED   = 8'd0;
  localparam logic [PIX_W-1:0] HUE_BASE_GREEN = 8'd85;
  localparam logic [PIX_W-1:0] HUE_BASE_BLUE  = 8'd171;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] hue;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] brightness;
  } hsv_t;

  // Classified pixel, handed from the front part to the back part.
  typedef struct packed {
    logic [NUM_W-1:0] sat_num;     // 255*span + max/2
    logic [NUM_W-1:0] hue_mag;     // |43*diff + span/2|
    logic             hue_neg;     // sign of the hue dividend
    logic [PIX_W-1:0] hue_base;    // sector base of the largest component
    logic [PIX_W-1:0] span;        // max - min
    logic [PIX_W-1:0] brightness;  // max
  } work_t;

endpackage

/* hdl/hsv_front.sv */
// Front part: registers an incoming pixel and classifies it for division.
module hsv_front import hsv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   work_valid,
  input  logic   work_ready,
  output work_t  work
);

  logic   held;
  pixel_t pix;

  logic [PIX_W-1:0]        mx;
  logic [PIX_W-1:0]        mn;
  logic [PIX_W-1:0]        span;
  logic [PIX_W-1:0]        base;
  logic signed [PIX_W:0]   diff;
  logic signed [NUM_W-1:0] hue_num;

  assign pixel_ready = !held || work_ready;
  assign work_valid  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (pixel_valid && pixel_ready) begin
      held <= 1'b1;
    end else if (work_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      pix <= pixel;
    end
  end

  always_comb begin
    // red wins ties, then green
    priority if (pix.red >= pix.green && pix.red >= pix.blue) begin
      mx   = pix.red;
      base = HUE_BASE_RED;
      diff = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
    end else if (pix.green >= pix.blue) begin
      mx   = pix.green;
      base = HUE_BASE_GREEN;
      diff = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
    end else begin
      mx   = pix.blue;
      base = HUE_BASE_BLUE;
      diff = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
    end

    mn = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    span = mx - mn;

    hue_num = NUM_W'(diff * HUE_SCALE) + NUM_W'({1'b0, span[PIX_W-1:1]});

    work.sat_num    = NUM_W'(span * SAT_SCALE) + NUM_W'({1'b0, mx[PIX_W-1:1]});
    work.hue_neg    = hue_num[NUM_W-1];
    work.hue_mag    = hue_num[NUM_W-1] ? NUM_W'(-hue_num) : NUM_W'(hue_num);
    work.hue_base   = base;
    work.span       = span;
    work.brightness = mx;
  end

endmodule

/* hdl/hsv_queue.sv */
// Short queue between the front and back parts.
module hsv_queue import hsv_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  work_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* hdl/hsv_back.sv */
// Back part: two pipelined restoring dividers, one quotient bit per stage.
module hsv_back import hsv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  work_valid,
  output logic  work_ready,
  input  work_t work,
  output logic  hsv_valid,
  input  logic  hsv_ready,
  output hsv_t  hsv
);

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [PIX_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    lane_t            sat;
    lane_t            hue;
    logic             hue_neg;
    logic [PIX_W-1:0] hue_base;
    logic [PIX_W-1:0] brightness;
  } stage_t;

  // One restoring step: try the divisor shifted to this quotient bit.
  function automatic lane_t div_step(lane_t l, int unsigned bit_pos);
    logic [NUM_W-1:0] trial;
    lane_t            r;
    trial = NUM_W'(l.den) << bit_pos;
    r     = l;
    if (l.rem >= trial) begin
      r.rem          = l.rem - trial;
      r.quo[bit_pos] = 1'b1;
    end
    return r;
  endfunction

  stage_t           st [QUO_W+1];
  logic [QUO_W:0]   st_valid;
  logic             advance;
  logic [PIX_W-1:0] hue_off;
  hsv_t             result;

  assign advance    = !hsv_valid || hsv_ready;
  assign work_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid  <= '0;
      hsv_valid <= 1'b0;
    end else if (advance) begin
      st_valid  <= {st_valid[QUO_W-1:0], work_valid};
      hsv_valid <= st_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0].sat.rem    <= work.sat_num;
      st[0].sat.den    <= work.brightness;
      st[0].sat.quo    <= '0;
      st[0].hue.rem    <= work.hue_mag;
      st[0].hue.den    <= work.span;
      st[0].hue.quo    <= '0;
      st[0].hue_neg    <= work.hue_neg;
      st[0].hue_base   <= work.hue_base;
      st[0].brightness <= work.brightness;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (advance) begin
        st[k+1].sat        <= div_step(st[k].sat, QUO_W - 1 - k);
        st[k+1].hue        <= div_step(st[k].hue, QUO_W - 1 - k);
        st[k+1].hue_neg    <= st[k].hue_neg;
        st[k+1].hue_base   <= st[k].hue_base;
        st[k+1].brightness <= st[k].brightness;
      end
    end
  end

  always_comb begin
    hue_off = st[QUO_W].hue_neg ? PIX_W'(-st[QUO_W].hue.quo) : PIX_W'(st[QUO_W].hue.quo);
    result.brightness = st[QUO_W].brightness;
    result.saturation = PIX_W'(st[QUO_W].sat.quo);
    result.hue        = st[QUO_W].hue_base + hue_off;
    if (st[QUO_W].brightness == '0) begin
      result = '0;
    end else if (st[QUO_W].sat.quo == '0) begin
      result.hue = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hsv <= result;
    end
  end

endmodule

/* hdl/rgb_to_hsv_8bit.sv */
// An accepted pixel passes through the front register, the queue, the divider stages and the output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the bit-per-stage divider pipeline.
// The front part keeps taking pixels while the output stalls until the queue fills.
// Reset (rst, synchronous, active high) empties the queue and drops all requests in flight.
// Results come out in the order the pixels were accepted.
module rgb_to_hsv_8bit import hsv_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   hsv_valid,
  input  logic   hsv_ready,
  output hsv_t   hsv
);

  // Front to queue.
  logic  fq_valid;
  logic  fq_ready;
  work_t fq_data;

  // Queue to back.
  logic  qb_valid;
  logic  qb_ready;
  work_t qb_data;

  // Front: hold one pixel, find max/min, pick the hue sector and form
  // both rounded dividends (saturation and hue) with the rounding term added.
  hsv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .work_valid  (fq_valid),
    .work_ready  (fq_ready),
    .work        (fq_data)
  );

  // Queue: absorb pixels while the back part is stalled by the consumer.
  hsv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // Back: run both divisions side by side, then apply the black and gray
  // special cases and the hue sector offset in the output register.
  hsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (qb_valid),
    .work_ready (qb_ready),
    .work       (qb_data),
    .hsv_valid  (hsv_valid),
    .hsv_ready  (hsv_ready),
    .hsv        (hsv)
  );

endmodule

/* hdl/hsv_checker.sv */
// Port-level checks for the RGB to HSV converter, bound to the top level.
module hsv_checker import hsv_pkg::*; (
  input logic   clk,
  input logic   rst,
  input logic   pixel_valid,
  input logic   pixel_ready,
  input pixel_t pixel,
  input logic   hsv_valid,
  input logic   hsv_ready,
  input hsv_t   hsv
);

  a_hold_request: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel))
    else $error("waiting pixel request changed or dropped");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && !hsv_ready |=> hsv_valid && $stable(hsv))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !hsv_valid)
    else $error("result valid right after reset");

  a_black: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.brightness == '0 |-> hsv.saturation == '0 && hsv.hue == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_gray: assert property (@(posedge clk) disable iff (rst)
    hsv_valid && hsv.saturation == '0 |-> hsv.hue == '0)
    else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_8bit hsv_checker u_hsv_checker (.*);

/* tb/sv/rgb_to_hsv_8bit_check.sv */
// Checker for the RGB to HSV converter: predicts each result and compares it.
module rgb_to_hsv_8bit_check import hsv_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  input  logic   pixel_ready,
  input  pixel_t pixel,
  input  logic   hsv_valid,
  input  logic   hsv_ready,
  input  hsv_t   hsv,
  output int     mismatch_count,
  output int     pending_count
);

  hsv_t expected_hsv_q[$];

  // Rounded quotient, truncated toward zero as signed int division does.
  function automatic int round_quotient(int num, int den);
    return (num + den / 2) / den;
  endfunction

  function automatic hsv_t predict_hsv(pixel_t p);
    int r;
    int g;
    int b;
    int top;
    int bottom;
    int span;
    int sat;
    int hue;
    hsv_t res;
    r = int'(p.red);
    g = int'(p.green);
    b = int'(p.blue);
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    bottom = r;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    res = '0;
    if (top == 0) return res;
    span = top - bottom;
    sat = round_quotient(SAT_SCALE * span, top);
    res.brightness = top[PIX_W-1:0];
    if (sat == 0) return res;
    // Ties go to red first, then green.
    if (top == r) hue = int'(HUE_BASE_RED) + round_quotient(HUE_SCALE * (g - b), span);
    else if (top == g) hue = int'(HUE_BASE_GREEN) + round_quotient(HUE_SCALE * (b - r), span);
    else hue = int'(HUE_BASE_BLUE) + round_quotient(HUE_SCALE * (r - g), span);
    res.hue = hue[PIX_W-1:0];
    res.saturation = sat[PIX_W-1:0];
    return res;
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    hsv_t want;
    if (!rst) begin
      if (pixel_valid && pixel_ready) expected_hsv_q.push_back(predict_hsv(pixel));
      if (hsv_valid && hsv_ready) begin
        if (expected_hsv_q.size() == 0) begin
          $error("unexpected result: hue %0d saturation %0d brightness %0d",
                 hsv.hue, hsv.saturation, hsv.brightness);
          mismatch_count++;
        end else begin
          want = expected_hsv_q.pop_front();
          if (hsv.hue !== want.hue) begin
            $error("hue: expected %0d, actual %0d", want.hue, hsv.hue);
            mismatch_count++;
          end
          if (hsv.saturation !== want.saturation) begin
            $error("saturation: expected %0d, actual %0d", want.saturation, hsv.saturation);
            mismatch_count++;
          end
          if (hsv.brightness !== want.brightness) begin
            $error("brightness: expected %0d, actual %0d", want.brightness, hsv.brightness);
            mismatch_count++;
          end
        end
      end
      pending_count <= expected_hsv_q.size();
    end
  end

endmodule

/* tb/sv/rgb_to_hsv_8bit_test.sv */
// Top of the RGB to HSV converter testbench: stimulus, flow control and verdict.
module rgb_to_hsv_8bit_test import hsv_pkg::*;;

  localparam int RANDOM_PER_PHASE = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 30;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   pixel_valid = 1'b0;
  logic   pixel_ready;
  pixel_t pixel = '0;
  logic   hsv_valid;
  logic   hsv_ready = 1'b0;
  hsv_t   hsv;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;
  int send_idle_pct = 0;   // chance per cycle that the sender holds back
  int recv_stall_pct = 0;  // chance per cycle that the receiver stalls

  always #4 clk = ~clk;

  rgb_to_hsv_8bit DUT (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel      (pixel),
    .hsv_valid  (hsv_valid),
    .hsv_ready  (hsv_ready),
    .hsv        (hsv)
  );

  rgb_to_hsv_8bit_check checker_inst (
    .clk           (clk),
    .rst           (rst),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .pixel         (pixel),
    .hsv_valid     (hsv_valid),
    .hsv_ready     (hsv_ready),
    .hsv           (hsv),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  // Watchdog: end the run with a failure once the cycle count passes CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: stall at random; one assignment per edge keeps it race free.
  always @(posedge clk) begin
    if (rst) begin
      hsv_ready <= 1'b0;
    end else begin
      hsv_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one pixel request, with random idle cycles in front of it, and
  // hold it until the block takes it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= '{red: r, green: g, blue: b};
    do @(posedge clk); while (!pixel_ready);
  endtask

  // Random pixel: half uniform, some with tied components, some dark or
  // nearly gray so that small spans and small values get exercised.
  task automatic send_random_pixel();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int pick;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    pick = $urandom_range(9);
    case (pick)
      0: g = r;
      1: b = r;
      2: b = g;
      3: begin
        r = 8'($urandom_range(3));
        g = 8'($urandom_range(3));
        b = 8'($urandom_range(3));
      end
      4: begin
        g = r + 8'($urandom_range(2)) - 8'd1;
        b = r + 8'($urandom_range(2)) - 8'd1;
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  // Run one phase of random traffic at the given idle and stall rates.
  task automatic run_phase(input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (RANDOM_PER_PHASE) send_random_pixel();
  endtask

  initial begin
    // Hold reset at the start, then release it once.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels: black, grays, primaries, ties for the largest
    // component, hue that wraps below zero, and the smallest spans.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd200, 8'd100);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd200);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd2, 8'd1, 8'd0);
    send_pixel(8'd100, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd50, 8'd255);

    // Random traffic under each flow-control pattern.
    run_phase(0, 0);
    run_phase(58, 0);
    run_phase(0, 58);
    run_phase(24, 24);

    // Drop valid, stop stalling and drain the pipeline.
    pixel_valid <= 1'b0;
    recv_stall_pct = 0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/hsv_pkg.sv
hdl/hsv_front.sv
hdl/hsv_queue.sv
hdl/hsv_back.sv
hdl/rgb_to_hsv_8bit.sv
hdl/hsv_checker.sv
tb/sv/rgb_to_hsv_8bit_check.sv
tb/sv/rgb_to_hsv_8bit_test.sv
